// ----- rtl/dibp_pkg.sv -----
`default_nettype none

package dibp_pkg;

  localparam int unsigned SYM_W   = 8;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned TS_W    = 9;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned WIDTH_W = 4;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [TS_W-1:0] TS_RESET = 9'd256;
  localparam logic [TS_W-1:0] TS_MAX   = 9'd256;

  localparam logic [0:0] REG_TABLE_SIZE = 1'b0;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_PACK  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_PACK,
    KIND_ERR,
    KIND_FLUSH
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [IDX_W-1:0]   idx;
    logic [WIDTH_W-1:0] width;
  } job_t;

  function automatic logic [WIDTH_W-1:0] idx_width(input logic [TS_W-1:0] ts);
    logic [TS_W:0]      n;
    logic [WIDTH_W-1:0] w;
    n = (ts > TS_MAX) ? {1'b0, TS_MAX} : {1'b0, ts};
    w = WIDTH_W'(1);
    for (int i = 1; i < 8; i++) begin
      if (((TS_W+1)'(1) << w) < n) begin
        w = w + WIDTH_W'(1);
      end
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dictionary_index_bit_packer.sv -----
// Channel  Direction  Handshake               Payload
// input    in         in_valid_i / in_stall_o  operation_i, symbol_i, entry_index_i
// output   out        out_valid_o / out_stall_i packed_word_o, status_o, last_o
// config   in         APB write/read           table_size at byte address 0
//
// One item per cycle sustained while no stall holds the input; the symbol map read
// is registered, so an item passes the front stage and then the queue before its
// result is registered at the output.
// Input stalls only when a pack or flush meets a full queue behind a stalled result.
// Reset is asynchronous: symbol map marked empty at once, packer restarts at an
// empty word; no clearing pass.
// A stalled result holds; the two-entry queue lets loads and clears proceed meanwhile.
`default_nettype none

module dictionary_index_bit_packer
  import dibp_pkg::*;
#(
  parameter int unsigned WORD_BITS   = 32,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [1:0]         operation_i,
  input  wire logic [SYM_W-1:0]   symbol_i,
  input  wire logic [POS_W-1:0]   entry_index_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic [OUT_W-1:0]   packed_word_o,
  output      logic               status_o,
  output      logic               last_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output      logic [PDATA_W-1:0] prdata,
  output      logic               pready
);

  logic [TS_W-1:0] table_size_q;
  logic            cfg_wr;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;
  job_t            push_job;
  job_t            head_job;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[PADDR_W-1] == REG_TABLE_SIZE);
  assign prdata = (paddr[PADDR_W-1] == REG_TABLE_SIZE)
                  ? PDATA_W'(table_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= TS_RESET;
    end else if (cfg_wr) begin
      table_size_q <= pwdata[TS_W-1:0];
    end
  end

  dibp_front #(
    .SYMBOL_BITS(SYMBOL_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .symbol_i     (symbol_i[SYMBOL_BITS-1:0]),
    .entry_index_i(entry_index_i),
    .table_size_i (table_size_q),
    .q_full_i     (q_full),
    .push_o       (push),
    .job_o        (push_job)
  );

  dibp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_job_i(push_job),
    .pop_i     (pop),
    .head_o    (head_job),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  dibp_back #(
    .WORD_BITS(WORD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_job),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .packed_word_o(packed_word_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// ----- rtl/dibp_front.sv -----
`default_nettype none

module dibp_front
  import dibp_pkg::*;
#(
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output      logic                   in_stall_o,
  input  wire logic [1:0]             operation_i,
  input  wire logic [SYMBOL_BITS-1:0] symbol_i,
  input  wire logic [POS_W-1:0]       entry_index_i,
  input  wire logic [TS_W-1:0]        table_size_i,
  input  wire logic                   q_full_i,
  output      logic                   push_o,
  output      job_t                   job_o
);

  localparam int unsigned NSYM = 2 ** SYMBOL_BITS;

  logic [POS_W-1:0]       map_mem [NSYM];
  logic [NSYM-1:0]        known_q, known_d;

  logic                   s1_valid_q, s1_valid_d;
  logic [1:0]             s1_op_q;
  logic [SYMBOL_BITS-1:0] s1_sym_q;
  logic [POS_W-1:0]       s1_pos_q;
  logic [POS_W-1:0]       rd_q;

  logic                   fwd_valid_q;
  logic [SYMBOL_BITS-1:0] fwd_sym_q;
  logic [POS_W-1:0]       fwd_idx_q;

  logic                   in_accept;
  logic                   needs_push;
  logic                   s1_adv;
  logic                   known;
  logic [POS_W-1:0]       stored;
  logic                   load_wr;
  logic [WIDTH_W-1:0]     width;
  logic [IDX_W-1:0]       idx_mask;

  assign needs_push = (s1_op_q == OP_PACK) || (s1_op_q == OP_FLUSH);
  assign s1_adv     = s1_valid_q && (!needs_push || !q_full_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign known  = known_q[s1_sym_q];
  assign stored = (fwd_valid_q && (fwd_sym_q == s1_sym_q)) ? fwd_idx_q : rd_q;

  assign load_wr = s1_adv && (s1_op_q == OP_LOAD)
                   && ({1'b0, s1_pos_q} < table_size_i)
                   && (!known || (s1_pos_q < stored));

  assign width    = idx_width(table_size_i);
  assign idx_mask = IDX_W'((16'd1 << width) - 16'd1);

  always_comb begin
    job_o.idx   = stored & idx_mask;
    job_o.width = width;
    case (s1_op_q)
      OP_FLUSH: job_o.kind = KIND_FLUSH;
      OP_PACK: begin
        if (!known || ({1'b0, stored} >= table_size_i)) begin
          job_o.kind = KIND_ERR;
        end else begin
          job_o.kind = KIND_PACK;
        end
      end
      default:  job_o.kind = KIND_ERR;
    endcase
  end

  assign push_o = s1_adv && needs_push;

  always_comb begin
    known_d = known_q;
    if (s1_adv && (s1_op_q == OP_CLEAR)) begin
      known_d = '0;
    end else if (load_wr) begin
      known_d[s1_sym_q] = 1'b1;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      known_q     <= '0;
      fwd_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      known_q    <= known_d;
      if (s1_adv) begin
        fwd_valid_q <= load_wr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q  <= operation_i;
      s1_sym_q <= symbol_i;
      s1_pos_q <= entry_index_i;
    end
    if (s1_adv) begin
      fwd_sym_q <= s1_sym_q;
      fwd_idx_q <= s1_pos_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      map_mem[s1_sym_q] <= s1_pos_q;
    end
    if (in_accept) begin
      rd_q <= map_mem[symbol_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dibp_queue.sv -----
`default_nettype none

module dibp_queue
  import dibp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t push_job_i,
  input  wire logic pop_i,
  output      job_t head_o,
  output      logic full_o,
  output      logic empty_o
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slots[rd_ptr_q];

  function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? next_ptr(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots[wr_ptr_q] <= push_job_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + QCNT_W'(1)))
    else $error("queue count did not advance");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// ----- rtl/dibp_back.sv -----
`default_nettype none

module dibp_back
  import dibp_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire job_t             head_i,
  input  wire logic             empty_i,
  output      logic             pop_o,
  output      logic             out_valid_o,
  input  wire logic             out_stall_i,
  output      logic [OUT_W-1:0] packed_word_o,
  output      logic             status_o,
  output      logic             last_o
);

  localparam int unsigned FREE_W = $clog2(WORD_BITS + 1);
  localparam logic [FREE_W-1:0] FREE_FULL = FREE_W'(WORD_BITS);

  logic [WORD_BITS-1:0] acc_q, acc_d;
  logic [FREE_W-1:0]    free_q, free_d;
  logic                 out_valid_q, out_valid_d;
  logic [OUT_W-1:0]     word_q;
  logic                 status_q;
  logic                 last_q;

  logic                 out_free;
  logic                 emit;
  logic [WORD_BITS-1:0] emit_word;
  logic                 emit_status;
  logic                 emit_last;
  logic [FREE_W-1:0]    w_f;
  logic [FREE_W-1:0]    rest;
  logic [FREE_W-1:0]    free_left;
  logic [WORD_BITS-1:0] idx_w;
  logic [WORD_BITS-1:0] merged;
  logic [63:0]          emit_ext;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = !empty_i && out_free;

  assign w_f       = FREE_W'(head_i.width);
  assign idx_w     = WORD_BITS'(head_i.idx);
  assign rest      = w_f - free_q;
  assign free_left = free_q - w_f;
  assign merged    = (acc_q << w_f) | idx_w;

  always_comb begin
    emit        = 1'b0;
    emit_word   = '0;
    emit_status = 1'b0;
    emit_last   = 1'b0;
    acc_d       = acc_q;
    free_d      = free_q;
    if (pop_o) begin
      case (head_i.kind)
        KIND_PACK: begin
          if (w_f <= free_q) begin
            if (free_left == '0) begin
              emit      = 1'b1;
              emit_word = merged;
              acc_d     = '0;
              free_d    = FREE_FULL;
            end else begin
              acc_d  = merged;
              free_d = free_left;
            end
          end else begin
            emit      = 1'b1;
            emit_word = (acc_q << free_q) | (idx_w >> rest);
            acc_d     = idx_w & ~({WORD_BITS{1'b1}} << rest);
            free_d    = FREE_FULL - rest;
          end
        end
        KIND_FLUSH: begin
          if (free_q != FREE_FULL) begin
            emit      = 1'b1;
            emit_word = acc_q << free_q;
            emit_last = 1'b1;
            acc_d     = '0;
            free_d    = FREE_FULL;
          end
        end
        KIND_ERR: begin
          emit        = 1'b1;
          emit_status = 1'b1;
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  assign emit_ext = 64'(emit_word);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      free_q      <= FREE_FULL;
    end else begin
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
      free_q      <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && emit) begin
      word_q   <= emit_ext[OUT_W-1:0];
      status_q <= emit_status;
      last_q   <= emit_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign packed_word_o = word_q;
  assign status_o      = status_q;
  assign last_o        = last_q;

`ifndef SYNTHESIS
  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q != '0) && (free_q <= FREE_FULL)) else $error("free bit count out of range");
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> !pop_o || !$past(pop_o) || $stable(word_q))
    else $error("result register changed under stall");
  a_empty_after_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && (head_i.kind == KIND_FLUSH)) |=> (free_q == FREE_FULL) && (acc_q == '0))
    else $error("accumulator not restarted after flush");
`endif

endmodule

`default_nettype wire
